// ===== rtl/core/tcd_pkg.sv =====
// Package for the termcap capability decoder: payload and event types,
// result and query codes, register indexes and character constants.
// No dependencies.
package tcd_pkg;

   // Default sizes handed down from the top level
   localparam int NAME_CHARS_DEF  = 8;
   localparam int NUMBER_BITS_DEF = 32;
   localparam int QUEUE_DEPTH     = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam logic [1:0] CSR_CAP_NAME   = 2'd0;
   localparam logic [1:0] CSR_CAP_LENGTH = 2'd1;
   localparam logic [1:0] CSR_QUERY_KIND = 2'd2;

   // Query kinds
   localparam logic [1:0] QK_NUMBER = 2'd0;
   localparam logic [1:0] QK_FLAG   = 2'd1;
   localparam logic [1:0] QK_STRING = 2'd2;

   // Result kinds
   localparam logic [2:0] RK_BYTE     = 3'd0;
   localparam logic [2:0] RK_STRDONE  = 3'd1;
   localparam logic [2:0] RK_NUMBER   = 3'd2;
   localparam logic [2:0] RK_FLAG     = 3'd3;
   localparam logic [2:0] RK_NOTFOUND = 3'd4;
   localparam logic [2:0] RK_WRONG    = 3'd5;
   localparam logic [2:0] RK_TRUNC    = 3'd6;

   // Characters
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_TAB     = 8'h09;

   typedef struct packed {
      logic [7:0] entry_byte;
      logic       entry_end;
   } req_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic [7:0]         decoded_byte;
      logic signed [31:0] number_value;
      logic               is_last;
   } rsp_type;

   // Configuration seen by the front end
   typedef struct packed {
      logic [63:0] cap_name;
      logic [3:0]  cap_length;
      logic [1:0]  query_kind;
   } cfg_type;

   // One classified item: its first result, and whether a truncated
   // status follows it
   typedef struct packed {
      rsp_type first;
      logic    trunc_after;
   } event_type;

endpackage

// ===== rtl/core/termcap_capability_decoder.sv =====
// Top level of the termcap capability decoder: configuration registers,
// front end, event queue and back end. Depends on tcd_pkg and tcd_* modules.
//
// Feed one entry byte per push; the block accepts one byte every cycle while
// full is low and needs no clearing pass after reset. Each byte is decoded
// in the cycle it is accepted and lands in a four-entry event queue; the
// result port then gives one item per cycle while pop is held, through its
// output register. A byte that yields both a decoded character and a
// truncated status gives two result items, the character first, and full
// rises only when the queue fills behind a stalled or doubled result stream.
// Registers: cap_name at byte address 0 (64 bits), cap_length at 8,
// query_kind at 16; a write applies from the next accepted byte on.
module termcap_capability_decoder
   import tcd_pkg::*;
#(
   parameter int NAME_CHARS  = NAME_CHARS_DEF,
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [63:0] cap_name_ff;
   logic [3:0]  cap_length_ff;
   logic [1:0]  query_kind_ff;
   logic [1:0]  csr_index;
   logic        csr_write;
   cfg_type     cfg;
   logic        accept;
   logic        front_valid;
   event_type   front_ev;
   logic        queue_valid;
   event_type   queue_head;
   logic        queue_pop;

   assign pready = 1'b1;
   assign csr_index = paddr[4:3];
   assign csr_write = psel && penable && pwrite && pready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_name_ff <= '0;
         cap_length_ff <= 4'd1;
         query_kind_ff <= QK_NUMBER;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAP_NAME:   cap_name_ff <= pwdata;
            CSR_CAP_LENGTH: cap_length_ff <= pwdata[3:0];
            CSR_QUERY_KIND: query_kind_ff <= pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      case (csr_index)
         CSR_CAP_NAME:   prdata = cap_name_ff;
         CSR_CAP_LENGTH: prdata = {60'b0, cap_length_ff};
         CSR_QUERY_KIND: prdata = {62'b0, query_kind_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.cap_name = cap_name_ff;
   assign cfg.cap_length = cap_length_ff;
   assign cfg.query_kind = query_kind_ff;

   assign accept = push && !full;

   tcd_front #(
      .NAME_CHARS  (NAME_CHARS),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .item     (req_data),
      .ev_valid (front_valid),
      .ev       (front_ev)
   );

   tcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .push_ev (front_ev),
      .full    (full),
      .pop     (queue_pop),
      .valid   (queue_valid),
      .head    (queue_head)
   );

   tcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (queue_valid),
      .ev       (queue_head),
      .ev_pop   (queue_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/core/tcd_front.sv =====
// Front end of the termcap capability decoder: name match and value decode,
// one entry byte per accepted item. Depends on tcd_pkg.
module tcd_front
   import tcd_pkg::*;
#(
   parameter int NAME_CHARS  = NAME_CHARS_DEF,
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      accept,
   input  req_type   item,
   output logic      ev_valid,
   output event_type ev
);

   localparam logic [3:0] PH_SCAN  = 4'd0;
   localparam logic [3:0] PH_KIND  = 4'd1;
   localparam logic [3:0] PH_NUM   = 4'd2;
   localparam logic [3:0] PH_STR   = 4'd3;
   localparam logic [3:0] PH_ESC   = 4'd4;
   localparam logic [3:0] PH_OCT1  = 4'd5;
   localparam logic [3:0] PH_OCT2  = 4'd6;
   localparam logic [3:0] PH_CARET = 4'd7;
   localparam logic [3:0] PH_DONE  = 4'd8;

   logic [3:0]             phase_ff, phase_in;
   logic [NAME_CHARS-1:0]  match_ff, match_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [7:0]             oct_ff, oct_in;

   logic [3:0] lim;
   logic [3:0] name_len;
   logic       zero_seen;
   logic [7:0] c;
   logic [7:0] oct_digit;
   logic       emit;
   logic       status;
   logic [2:0] status_kind;
   rsp_type    first;

   assign c = item.entry_byte;
   assign oct_digit = c - CH_ZERO;

   // Work out the name length: limit, then cut at the first zero byte
   always_comb begin
      lim = (cfg.cap_length > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : cfg.cap_length;
      name_len = lim;
      zero_seen = 1'b0;
      for (int k = 0; k < NAME_CHARS; k++) begin
         if (!zero_seen && (4'(k) < lim) && (cfg.cap_name[8*k +: 8] == 8'h00)) begin
            name_len = 4'(k);
            zero_seen = 1'b1;
         end
      end
   end

   // Advance the decode state for one byte and build its results
   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      acc_in = acc_ff;
      oct_in = oct_ff;
      emit = 1'b0;
      status = 1'b0;
      status_kind = RK_NOTFOUND;
      first = '0;
      if (accept) begin
         case (phase_ff)
            PH_SCAN: begin
               match_in = '0;
               for (int k = 0; k < NAME_CHARS; k++) begin
                  if (match_ff[k] && (4'(k) < name_len) &&
                      (c == cfg.cap_name[8*k +: 8])) begin
                     if (4'(k + 1) == name_len) begin
                        phase_in = PH_KIND;
                     end else if (k + 1 < NAME_CHARS) begin
                        match_in[(k + 1) % NAME_CHARS] = 1'b1;
                     end
                  end
               end
               if ((c == CH_COLON) && (name_len != 4'd0)) begin
                  match_in[0] = 1'b1;
               end
               if (phase_in == PH_KIND) begin
                  match_in = '0;
               end
            end
            PH_KIND: begin
               if ((cfg.query_kind == QK_NUMBER) && (c == CH_HASH)) begin
                  acc_in = '0;
                  phase_in = PH_NUM;
               end else if ((cfg.query_kind == QK_FLAG) && (c == CH_COLON)) begin
                  status = 1'b1;
                  status_kind = RK_FLAG;
                  phase_in = PH_DONE;
               end else if ((cfg.query_kind == QK_STRING) && (c == CH_EQUAL)) begin
                  phase_in = PH_STR;
               end else begin
                  status = 1'b1;
                  status_kind = RK_WRONG;
                  phase_in = PH_DONE;
               end
            end
            PH_NUM: begin
               if (c == CH_COLON) begin
                  status = 1'b1;
                  status_kind = RK_NUMBER;
                  phase_in = PH_DONE;
               end else begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + NUMBER_BITS'(c)
                           - NUMBER_BITS'(CH_ZERO);
               end
            end
            PH_STR: begin
               if (c == CH_COLON) begin
                  status = 1'b1;
                  status_kind = RK_STRDONE;
                  phase_in = PH_DONE;
               end else if (c == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else if (c == CH_CARET) begin
                  phase_in = PH_CARET;
               end else begin
                  emit = 1'b1;
                  first.decoded_byte = c;
               end
            end
            PH_ESC: begin
               phase_in = PH_STR;
               if ((c >= CH_ZERO) && (c <= CH_SEVEN)) begin
                  oct_in = {c[1:0], 6'b0};
                  phase_in = PH_OCT1;
               end else begin
                  emit = 1'b1;
                  case (c)
                     CH_UPPER_E: first.decoded_byte = CH_ESC;
                     CH_LOWER_B: first.decoded_byte = CH_BS;
                     CH_LOWER_F: first.decoded_byte = CH_FF;
                     CH_LOWER_N: first.decoded_byte = CH_LF;
                     CH_LOWER_R: first.decoded_byte = CH_CR;
                     CH_LOWER_T: first.decoded_byte = CH_TAB;
                     default:    first.decoded_byte = c;
                  endcase
               end
            end
            PH_OCT1: begin
               oct_in = oct_ff + {oct_digit[4:0], 3'b0};
               phase_in = PH_OCT2;
            end
            PH_OCT2: begin
               emit = 1'b1;
               first.decoded_byte = oct_ff + oct_digit;
               oct_in = '0;
               phase_in = PH_STR;
            end
            PH_CARET: begin
               emit = 1'b1;
               first.decoded_byte = c - CH_AT;
               phase_in = PH_STR;
            end
            default: begin
            end
         endcase

         // Close the entry on its last byte
         if (item.entry_end) begin
            if ((phase_in == PH_SCAN) || (phase_in == PH_KIND)) begin
               status = 1'b1;
               status_kind = RK_NOTFOUND;
            end else if (phase_in != PH_DONE) begin
               status = 1'b1;
               status_kind = RK_TRUNC;
            end
            phase_in = PH_SCAN;
            match_in = '0;
            acc_in = '0;
            oct_in = '0;
         end
      end

      if (!emit) begin
         first.result_kind = status_kind;
         first.is_last = 1'b1;
         first.decoded_byte = '0;
         if (status_kind == RK_NUMBER) begin
            first.number_value = 32'($signed(acc_ff));
         end
      end else begin
         first.result_kind = RK_BYTE;
      end
   end

   assign ev_valid = accept && (emit || status);
   assign ev.first = first;
   assign ev.trunc_after = emit && status;

   // Hold decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SCAN;
         match_ff <= '0;
         acc_ff <= '0;
         oct_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         acc_ff <= acc_in;
         oct_ff <= oct_in;
      end
   end

endmodule

// ===== rtl/core/tcd_queue.sv =====
// Short event queue between the front and back ends of the termcap
// capability decoder. Depends on tcd_pkg.
module tcd_queue
   import tcd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_ev,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output event_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   event_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in;
   logic [PTR_W-1:0]      rd_ff, rd_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed event
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_ev;
      end
   end

endmodule

// ===== rtl/core/tcd_back.sv =====
// Back end of the termcap capability decoder: expands queued events into
// result items behind an output register. Depends on tcd_pkg.
module tcd_back
   import tcd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      ev_valid,
   input  event_type ev,
   output logic      ev_pop,
   output logic      empty,
   input  logic      pop,
   output rsp_type   rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    pend_ff, pend_in;
   logic    load;
   rsp_type trunc_rsp;

   always_comb begin
      trunc_rsp = '0;
      trunc_rsp.result_kind = RK_TRUNC;
      trunc_rsp.is_last = 1'b1;
   end

   assign load = !out_valid_ff || pop;

   // Refill the output register: pending status first, then the queue head
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      pend_in = pend_ff;
      ev_pop = 1'b0;
      if (load) begin
         if (pend_ff) begin
            out_in = trunc_rsp;
            out_valid_in = 1'b1;
            pend_in = 1'b0;
         end else if (ev_valid) begin
            out_in = ev.first;
            pend_in = ev.trunc_after;
            ev_pop = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

// ===== bench/tb_termcap_capability_decoder.sv =====
`timescale 1ns / 100ps
// Self-checking bench for termcap_capability_decoder: a directed list of entries, then
// random entries under changing register settings, checked against a local decoder model.
// Depends on tcd_pkg and the decoder RTL.
module tb_termcap_capability_decoder;
   import tcd_pkg::*;

   localparam int CYCLE_LIMIT    = 200_000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int ITEMS_PER_MODE = 420;
   localparam int HOLD_CYCLES    = 80;

   localparam logic [1:0]  QK_INVALID    = 2'd3;
   localparam logic [7:0]  CH_LOWER_A    = 8'h61;
   // "p" then "r", first character in the low byte
   localparam logic [63:0] PRESSURE_NAME = 64'h7270;

   typedef enum logic [3:0] {
      SCAN_COLON, READ_KIND, READ_NUMBER, READ_STRING, READ_ESCAPE,
      READ_OCTAL1, READ_OCTAL2, READ_CARET, ENTRY_DONE
   } scan_state_type;

   typedef struct {
      bit         is_write;
      logic [1:0] reg_idx;
      logic [63:0] wdata;
      req_type    item;
      bit         typed;
      rsp_type    typed_rsp;
   } plan_row_type;

   // DUT signals
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   req_type               req_data = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Register copy, decoder state and results still owed by the block
   logic [63:0] cfg_name = '0;
   logic [3:0]  cfg_len = 4'd1;
   logic [1:0]  cfg_kind = QK_NUMBER;
   scan_state_type dec_state = SCAN_COLON;
   logic [7:0]  cand_pos = '0;
   logic [31:0] num_acc = '0;
   logic [7:0]  oct_acc = '0;
   rsp_type     step_results[$];
   rsp_type     awaited_results[$];

   // Stimulus control shared between processes
   plan_row_type stim_plan[$];
   logic [7:0]  entry_text[$];
   logic [7:0]  escape_letters[10] = '{CH_UPPER_E, CH_LOWER_B, CH_LOWER_F, CH_LOWER_N,
                                      CH_LOWER_R, CH_LOWER_T, CH_BSLASH, CH_COLON,
                                      CH_CARET, CH_AT};
   bit          typed_expect = 1'b0;
   rsp_type     typed_rsp = '0;
   int          send_idle_pct = 17;
   int          recv_idle_pct = 55;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          mode_items = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   termcap_capability_decoder u_top (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [7:0] name_char(input int k);
      return cfg_name[8*k +: 8];
   endfunction

   // Name length after the NAME_CHARS clip and the cut at the first zero byte
   function automatic int eff_name_len();
      int lim;
      lim = (cfg_len > NAME_CHARS_DEF) ? NAME_CHARS_DEF : int'(cfg_len);
      for (int k = 0; k < lim; k++)
         if (name_char(k) == 8'h00) return k;
      return lim;
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] kind, input logic [7:0] value,
                                        input logic [31:0] num, input logic last);
      rsp_type r;
      r.result_kind  = kind;
      r.decoded_byte = value;
      r.number_value = $signed(num);
      r.is_last      = last;
      return r;
   endfunction

   task automatic close_query(input logic [2:0] kind, input logic [31:0] num);
      step_results.push_back(make_rsp(kind, 8'h00, num, 1'b1));
      dec_state = ENTRY_DONE;
   endtask

   task automatic emit_char(input logic [7:0] value);
      step_results.push_back(make_rsp(RK_BYTE, value, 32'd0, 1'b0));
   endtask

   // Advance the decoder by one entry byte, leaving its results in step_results
   task automatic decode_entry_byte(input req_type r);
      logic [7:0] c;
      logic [7:0] reach;
      bit         hit;
      int         len;
      c = r.entry_byte;
      step_results.delete();
      case (dec_state)
         SCAN_COLON: begin
            // every ':' opens a candidate if the name is not empty; candidates advance in parallel
            len   = eff_name_len();
            reach = '0;
            hit   = 1'b0;
            for (int k = 0; k < len; k++) begin
               if (cand_pos[k] && c == name_char(k)) begin
                  if (k + 1 == len) hit = 1'b1;
                  else reach[k+1] = 1'b1;
               end
            end
            if (c == CH_COLON && len > 0) reach[0] = 1'b1;
            if (hit) begin
               dec_state = READ_KIND;
               cand_pos  = '0;
            end else begin
               cand_pos = reach;
            end
         end
         READ_KIND: begin
            if (cfg_kind == QK_NUMBER && c == CH_HASH) begin
               num_acc   = '0;
               dec_state = READ_NUMBER;
            end else if (cfg_kind == QK_FLAG && c == CH_COLON) begin
               close_query(RK_FLAG, 32'd0);
            end else if (cfg_kind == QK_STRING && c == CH_EQUAL) begin
               dec_state = READ_STRING;
            end else begin
               close_query(RK_WRONG, 32'd0);
            end
         end
         READ_NUMBER: begin
            if (c == CH_COLON) close_query(RK_NUMBER, num_acc);
            else num_acc = num_acc * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
         end
         READ_STRING: begin
            if (c == CH_COLON) close_query(RK_STRDONE, 32'd0);
            else if (c == CH_BSLASH) dec_state = READ_ESCAPE;
            else if (c == CH_CARET) dec_state = READ_CARET;
            else emit_char(c);
         end
         READ_ESCAPE: begin
            dec_state = READ_STRING;
            if (c >= CH_ZERO && c <= CH_SEVEN) begin
               oct_acc   = (c - CH_ZERO) << 6;
               dec_state = READ_OCTAL1;
            end else if (c == CH_UPPER_E) emit_char(CH_ESC);
            else if (c == CH_LOWER_B) emit_char(CH_BS);
            else if (c == CH_LOWER_F) emit_char(CH_FF);
            else if (c == CH_LOWER_N) emit_char(CH_LF);
            else if (c == CH_LOWER_R) emit_char(CH_CR);
            else if (c == CH_LOWER_T) emit_char(CH_TAB);
            else emit_char(c);
         end
         READ_OCTAL1: begin
            oct_acc   = oct_acc + ((c - CH_ZERO) << 3);
            dec_state = READ_OCTAL2;
         end
         READ_OCTAL2: begin
            emit_char(oct_acc + c - CH_ZERO);
            oct_acc   = '0;
            dec_state = READ_STRING;
         end
         READ_CARET: begin
            emit_char(c - CH_AT);
            dec_state = READ_STRING;
         end
         default: ;
      endcase
      // close the entry: report a miss or a cut-off value, then start over
      if (r.entry_end) begin
         if (dec_state == SCAN_COLON || dec_state == READ_KIND)
            step_results.push_back(make_rsp(RK_NOTFOUND, 8'h00, 32'd0, 1'b1));
         else if (dec_state != ENTRY_DONE)
            step_results.push_back(make_rsp(RK_TRUNC, 8'h00, 32'd0, 1'b1));
         dec_state = SCAN_COLON;
         cand_pos  = '0;
         num_acc   = '0;
         oct_acc   = '0;
      end
   endtask

   // ---------------------------------------------------------- monitoring

   // Predict on every accepted item, check every accepted result
   always @(posedge clock) begin : monitor
      rsp_type exp_rsp;
      if (!reset) begin
         if (push && !full) begin
            decode_entry_byte(req_data);
            if (typed_expect) awaited_results.push_back(typed_rsp);
            else foreach (step_results[i]) awaited_results.push_back(step_results[i]);
         end
         if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got kind %0d byte %02h %s",
                        $time, rsp_data.result_kind, rsp_data.decoded_byte,
                        $sformatf("num %0d last %0d", rsp_data.number_value,
                                  rsp_data.is_last));
            end else begin
               exp_rsp = awaited_results.pop_front();
               if (rsp_data !== exp_rsp) begin
                  error_count++;
                  $display("%0t: expected kind %0d byte %02h num %0d last %0d, %s",
                           $time, exp_rsp.result_kind, exp_rsp.decoded_byte,
                           exp_rsp.number_value, exp_rsp.is_last,
                           $sformatf("got kind %0d byte %02h num %0d last %0d",
                                     rsp_data.result_kind, rsp_data.decoded_byte,
                                     rsp_data.number_value, rsp_data.is_last));
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(1, 100) > recv_idle_pct);
      end
   end

   // ------------------------------------------------------------ stimulus

   // Drop push, wait until every owed result is in, let the pipeline settle
   task automatic wait_for_idle();
      push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Registers sit at 8-byte spacing since cap_name is 64 bits wide
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      wait_for_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         CSR_CAP_NAME:   cfg_name = value;
         CSR_CAP_LENGTH: cfg_len  = value[3:0];
         CSR_QUERY_KIND: cfg_kind = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Offer one item, with random idle cycles ahead of it, and hold it until taken
   task automatic send_item(input req_type item, input bit typed, input rsp_type t_rsp);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push         <= 1'b1;
      req_data     <= item;
      typed_expect <= typed;
      typed_rsp    <= t_rsp;
      @(posedge clock);
      while (!(push && !full)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_entry();
      foreach (entry_text[i]) begin
         send_item('{entry_byte: entry_text[i], entry_end: (i == entry_text.size() - 1)},
                   1'b0, '0);
         mode_items++;
      end
   endtask

   task automatic plan_write(input logic [1:0] idx, input logic [63:0] value);
      plan_row_type row;
      row          = '{default: '0};
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.wdata    = value;
      stim_plan.push_back(row);
   endtask

   task automatic plan_byte(input logic [7:0] value, input bit ends, input bit typed,
                            input logic [2:0] kind, input logic [31:0] num);
      plan_row_type row;
      row           = '{default: '0};
      row.item      = '{entry_byte: value, entry_end: ends};
      row.typed     = typed;
      row.typed_rsp = make_rsp(kind, 8'h00, num, 1'b1);
      stim_plan.push_back(row);
   endtask

   // The typed expectation, if any, belongs to the final character
   task automatic plan_text(input string s, input bit ends, input bit typed,
                            input logic [2:0] kind, input logic [31:0] num);
      bit tail;
      for (int i = 0; i < s.len(); i++) begin
         tail = (i == s.len() - 1);
         plan_byte(s[i], ends && tail, typed && tail, kind, num);
      end
   endtask

   task automatic push_name();
      int len;
      len = eff_name_len();
      for (int k = 0; k < len; k++) entry_text.push_back(name_char(k));
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 3))
         0:       return CH_COLON;
         1:       return name_char($urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Pick a register setting; the first one is the widest case
   task automatic randomize_config(input int phase_no);
      logic [63:0] name;
      logic [3:0]  len;
      logic [1:0]  kind;
      int          r;
      case ($urandom_range(0, 7))
         0:       name = '1;
         1:       name = '0;
         2:       name = {$urandom, $urandom};
         default: begin
            for (int k = 0; k < 8; k++) begin
               r = $urandom_range(0, 19);
               if (r < 14) name[8*k +: 8] = CH_LOWER_A + 8'($urandom_range(0, 2));
               else if (r < 16) name[8*k +: 8] = CH_COLON;
               else if (r == 16) name[8*k +: 8] = 8'h00;
               else name[8*k +: 8] = 8'($urandom_range(0, 255));
            end
         end
      endcase
      case ($urandom_range(0, 7))
         0:       len = 4'd0;
         1:       len = 4'd15;
         2:       len = 4'd8;
         default: len = 4'($urandom_range(1, 4));
      endcase
      kind = ($urandom_range(0, 9) == 0) ? QK_INVALID : 2'($urandom_range(0, 2));
      if (phase_no == 0) begin
         name = '1;
         len  = 4'd15;
         kind = QK_STRING;
      end
      csr_write(CSR_CAP_NAME, name);
      csr_write(CSR_CAP_LENGTH, {60'd0, len});
      csr_write(CSR_QUERY_KIND, {62'd0, kind});
   endtask

   // Mostly well-formed entries around the configured name, some plain noise
   task automatic build_entry();
      bit trunc;
      int r;
      entry_text.delete();
      if ($urandom_range(0, 9) < 3) begin
         repeat ($urandom_range(1, 12)) entry_text.push_back(noise_byte());
         return;
      end
      // leading fields, some of them near misses on the name
      repeat ($urandom_range(0, 2)) begin
         entry_text.push_back(CH_COLON);
         repeat ($urandom_range(0, 4)) entry_text.push_back(noise_byte());
      end
      entry_text.push_back(CH_COLON);
      push_name();
      trunc = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) entry_text.push_back(8'($urandom_range(0, 255)));
      else begin
         case (cfg_kind)
            QK_NUMBER: entry_text.push_back(CH_HASH);
            QK_STRING: entry_text.push_back(CH_EQUAL);
            default:   entry_text.push_back(CH_COLON);
         endcase
      end
      if (cfg_kind == QK_NUMBER) begin
         // up to twelve digits, enough to wrap the accumulator
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) == 0) entry_text.push_back(8'($urandom_range(0, 255)));
            else entry_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         end
         if (!trunc) entry_text.push_back(CH_COLON);
      end else if (cfg_kind == QK_STRING) begin
         repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
               entry_text.push_back(8'($urandom_range(0, 255)));
            end else if (r < 6) begin
               entry_text.push_back(CH_BSLASH);
               if ($urandom_range(0, 10) == 0) entry_text.push_back(8'($urandom_range(0, 255)));
               else entry_text.push_back(escape_letters[$urandom_range(0, 9)]);
            end else if (r < 8) begin
               // octal escape always eats two more bytes, whatever they are
               entry_text.push_back(CH_BSLASH);
               entry_text.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
               repeat (2) begin
                  if ($urandom_range(0, 4) == 0) entry_text.push_back(8'($urandom_range(0, 255)));
                  else entry_text.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
               end
            end else begin
               entry_text.push_back(CH_CARET);
               entry_text.push_back(8'($urandom_range(0, 255)));
            end
         end
         if (!trunc) entry_text.push_back(CH_COLON);
      end
      if (!trunc)
         repeat ($urandom_range(0, 3)) entry_text.push_back(8'($urandom_range(0, 255)));
   endtask

   // Long plain string while the result side holds off, so the block fills up
   task automatic run_pressure_entry();
      csr_write(CSR_CAP_NAME, PRESSURE_NAME);
      csr_write(CSR_CAP_LENGTH, 64'd2);
      csr_write(CSR_QUERY_KIND, {62'd0, QK_STRING});
      entry_text.delete();
      entry_text.push_back(CH_COLON);
      push_name();
      entry_text.push_back(CH_EQUAL);
      repeat (40) entry_text.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
      entry_text.push_back(CH_COLON);
      holds_asked++;
      send_entry();
   endtask

   initial begin : stimulus
      int phase_no;
      phase_no = 0;

      // Directed entries
      plan_byte(8'hFF, 1'b1, 1'b1, RK_NOTFOUND, 32'd0);      // empty name never matches
      plan_write(CSR_CAP_NAME, 64'h73);                      // "s"
      plan_write(CSR_CAP_LENGTH, 64'd1);
      plan_write(CSR_QUERY_KIND, {62'd0, QK_NUMBER});
      plan_text(":s#9:", 1'b1, 1'b1, RK_NUMBER, 32'd9);
      plan_write(CSR_QUERY_KIND, {62'd0, QK_STRING});
      plan_text(":s=\\E^?\\101", 1'b1, 1'b0, RK_BYTE, 32'd0); // last byte also truncates
      plan_write(CSR_QUERY_KIND, {62'd0, QK_INVALID});
      plan_text(":s:", 1'b1, 1'b1, RK_WRONG, 32'd0);
      plan_text(":s", 1'b1, 1'b1, RK_NOTFOUND, 32'd0);       // name on the final byte
      // shorten the name in the middle of an entry
      plan_write(CSR_CAP_NAME, 64'h6261);                    // "ab"
      plan_write(CSR_CAP_LENGTH, 64'd2);
      plan_write(CSR_QUERY_KIND, {62'd0, QK_FLAG});
      plan_text(":a", 1'b0, 1'b0, RK_BYTE, 32'd0);
      plan_write(CSR_CAP_LENGTH, 64'd1);
      plan_text("b:a:", 1'b1, 1'b1, RK_FLAG, 32'd0);

      // Reset
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_plan[i]) begin
         if (stim_plan[i].is_write) csr_write(stim_plan[i].reg_idx, stim_plan[i].wdata);
         else send_item(stim_plan[i].item, stim_plan[i].typed, stim_plan[i].typed_rsp);
      end

      // Random entries under three idle patterns
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 17; recv_idle_pct = 55; end
            1:       begin send_idle_pct = 55; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         mode_items = 0;
         run_pressure_entry();
         while (mode_items < ITEMS_PER_MODE) begin
            randomize_config(phase_no);
            phase_no++;
            repeat ($urandom_range(3, 6)) begin
               build_entry();
               send_entry();
            end
         end
      end

      wait_for_idle();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tcd_pkg.sv
rtl/core/tcd_front.sv
rtl/core/tcd_queue.sv
rtl/core/tcd_back.sv
rtl/core/termcap_capability_decoder.sv
bench/tb_termcap_capability_decoder.sv
